@@ src/pcmd_pkg.sv @@
// Package for the path-to-motion-command converter: command codes, count widths,
// result types and the helpers that build a result list. Used by every module in src.
`default_nettype none

package pcmd_pkg;

    localparam int COUNT_MAX = 1023;
    localparam int CNT_W     = 10;                      // width of the repeat_count field
    localparam int RUN_W     = $clog2(COUNT_MAX + 3);   // run length reaches COUNT_MAX + 2
    localparam int FWD_W     = $clog2(COUNT_MAX + 1);
    localparam int MAX_RES   = 5;
    localparam int NUM_W     = $clog2(MAX_RES + 1);
    localparam int IDX_W     = $clog2(MAX_RES);

    typedef enum logic [2:0] {
        CMD_FWD  = 3'd0,
        CMD_R90  = 3'd1,
        CMD_L90  = 3'd2,
        CMD_R45  = 3'd3,
        CMD_L45  = 3'd4,
        CMD_DIAG = 3'd5,
        CMD_ERR  = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        t_cmd             cmd;
    } t_result;

    typedef struct packed {
        logic [NUM_W-1:0]        num;
        t_result [MAX_RES-1:0]   item;
    } t_res_list;

    // Append one result at the end of the list.
    function automatic t_res_list push(t_res_list l, t_cmd c, logic [CNT_W-1:0] n);
        t_res_list r;
        r = l;
        if (r.num < NUM_W'(MAX_RES)) begin
            r.item[r.num[IDX_W-1:0]].cmd = c;
            r.item[r.num[IDX_W-1:0]].cnt = n;
            r.num = r.num + 1'b1;
        end
        return r;
    endfunction

    // Append the commands that close an open turn run.
    function automatic t_res_list close_run(t_res_list l, logic [RUN_W-1:0] len,
                                            logic first_r, logic last_r);
        t_res_list        r;
        logic [RUN_W-1:0] d;
        r = l;
        d = len - RUN_W'(2);
        if (len == RUN_W'(1)) begin
            r = push(r, first_r ? CMD_R90 : CMD_L90, '0);
        end else if (len >= RUN_W'(2)) begin
            if (d > RUN_W'(COUNT_MAX)) begin
                d = RUN_W'(COUNT_MAX);
            end
            r = push(r, first_r ? CMD_R45 : CMD_L45, '0);
            if (d != '0) begin
                r = push(r, CMD_DIAG, d[CNT_W-1:0]);
            end
            r = push(r, last_r ? CMD_R45 : CMD_L45, '0);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/pcmd_step.sv @@
// Step decoder: holds heading, turn-run and forward-count state and builds the
// list of results one path step causes. Depends on pcmd_pkg.
`default_nettype none

module pcmd_step
    import pcmd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_diag,
    input  wire logic      i_accept,
    input  wire logic [1:0] i_heading,
    input  wire logic      i_end,
    output t_res_list      o_list
);

    logic             r_diag;
    logic [1:0]       r_heading, n_heading;
    logic [RUN_W-1:0] r_run_len, n_run_len;
    logic             r_first, n_first;
    logic             r_last, n_last;
    logic [FWD_W-1:0] r_fwd, n_fwd;

    logic [1:0] diff;
    logic       right;
    t_res_list  lst;

    always_comb begin
        diff      = i_heading - r_heading;
        right     = (diff == 2'd1);
        lst       = '0;
        n_heading = r_heading;
        n_run_len = r_run_len;
        n_first   = r_first;
        n_last    = r_last;
        n_fwd     = r_fwd;

        if (diff == 2'd2) begin
            // Reversal: report and otherwise ignore the step.
            lst = push(lst, CMD_ERR, '0);
        end else if (diff == 2'd0) begin
            lst       = close_run(lst, n_run_len, n_first, n_last);
            n_run_len = '0;
            n_first   = 1'b0;
            n_last    = 1'b0;
            if (n_fwd < FWD_W'(COUNT_MAX)) begin
                n_fwd = n_fwd + 1'b1;
            end
            n_heading = i_heading;
        end else begin
            if (n_fwd != '0) begin
                lst   = push(lst, CMD_FWD, CNT_W'(n_fwd));
                n_fwd = '0;
            end
            if (r_diag) begin
                if (n_run_len != '0 && right != n_last) begin
                    if (n_run_len < RUN_W'(COUNT_MAX + 2)) begin
                        n_run_len = n_run_len + 1'b1;
                    end
                    n_last = right;
                end else begin
                    lst       = close_run(lst, n_run_len, n_first, n_last);
                    n_run_len = RUN_W'(1);
                    n_first   = right;
                    n_last    = right;
                end
            end else begin
                lst       = close_run(lst, n_run_len, n_first, n_last);
                n_run_len = '0;
                n_first   = 1'b0;
                n_last    = 1'b0;
                lst       = push(lst, right ? CMD_R90 : CMD_L90, '0);
            end
            n_heading = i_heading;
        end

        if (i_end) begin
            // End of path: close whatever is open, then return to reset.
            lst = close_run(lst, n_run_len, n_first, n_last);
            if (n_fwd != '0) begin
                lst = push(lst, CMD_FWD, CNT_W'(n_fwd));
            end
            n_heading = '0;
            n_run_len = '0;
            n_first   = 1'b0;
            n_last    = 1'b0;
            n_fwd     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag    <= 1'b0;
            r_heading <= '0;
            r_run_len <= '0;
            r_first   <= 1'b0;
            r_last    <= 1'b0;
            r_fwd     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_diag <= i_cfg_diag;
            end
            if (i_accept) begin
                r_heading <= n_heading;
                r_run_len <= n_run_len;
                r_first   <= n_first;
                r_last    <= n_last;
                r_fwd     <= n_fwd;
            end
        end
    end

    assign o_list = lst;

endmodule

`default_nettype wire

@@ src/pcmd_outbuf.sv @@
// Result buffer: holds the result list of one step and hands it out one item
// per handshake, marking the final one. Depends on pcmd_pkg.
`default_nettype none

module pcmd_outbuf
    import pcmd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_res_list i_list,
    input  wire logic      i_ready,
    output logic           o_valid,
    output t_result        o_result,
    output logic           o_last,
    output logic           o_can_load
);

    logic [NUM_W-1:0]      r_num;
    t_result [MAX_RES-1:0] r_items;
    logic                  pop;

    assign o_valid    = (r_num != '0);
    assign o_last     = (r_num == NUM_W'(1));
    assign o_result   = r_items[0];
    assign pop        = o_valid && i_ready;
    // Free once empty, or as the final buffered item leaves in this cycle.
    assign o_can_load = (r_num == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= '0;
        end else if (i_load) begin
            r_num <= i_list.num;
        end else if (pop) begin
            r_num <= r_num - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_list.item;
        end else if (pop) begin
            r_items <= r_items >> $bits(t_result);
        end
    end

endmodule

`default_nettype wire

@@ src/path_to_motion_commands_top.sv @@
// The first result of a path step is offered in the cycle after the step is taken.
// Throughput: one step per cycle while each step causes at most one result and the receiver
// is ready; a step with k results (up to five) holds off the next step until its last one leaves.
// Reset: i_rst_n is synchronous and active low; it clears heading, run and forward state,
// the diagonal mode register and the result buffer.
// Top level of the path-to-motion-command converter; depends on pcmd_pkg, pcmd_step
// and pcmd_outbuf.
`default_nettype none

module path_to_motion_commands_top
    import pcmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration write channel: diagonal_enable only.
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_data,
    output logic             o_cfg_ready,

    // Path steps in.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [1:0] heading, [7:2] zero
    input  wire logic        s_axis_tlast,   // end_of_path

    // Motion commands out.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [2:0] command, [12:3] repeat_count, [15:13] zero
    output logic             m_axis_tlast    // last_result
);

    t_res_list list;
    t_result   result;
    logic      can_load;
    logic      accept;

    // The configuration register is always writable; the user must change it only while idle (unchecked).
    assign o_cfg_ready = 1'b1;

    // An item is taken whenever the result buffer is free or frees up in this cycle,
    // so a waiting result never stops the input side for longer than its own drain.
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    // The step decoder turns each item into a complete ordered list of results in a
    // single pass and updates its held state at the same edge.
    pcmd_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_diag (i_cfg_data),
        .i_accept   (accept),
        .i_heading  (s_axis_tdata[1:0]),
        .i_end      (s_axis_tlast),
        .o_list     (list)
    );

    // The list is registered and handed out one item per output handshake. A step
    // with no results loads an empty list and leaves the buffer free.
    pcmd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_list     (list),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_result   (result),
        .o_last     (m_axis_tlast),
        .o_can_load (can_load)
    );

    assign m_axis_tdata = {3'b000, result};

endmodule

`default_nettype wire

@@ verif/path_to_motion_commands_top_tb.sv @@
// Self-checking testbench for the path-to-motion-command converter: directed paths,
// output back-pressure and random paths, checked against an in-bench predictor.
// Depends on pcmd_pkg and path_to_motion_commands_top from src.
`default_nettype none

module path_to_motion_commands_top_tb
    import pcmd_pkg::*;
();

    // Cycles allowed after the last result before the block is taken to be idle.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 600000;

    // A step is described relative to the held heading; the value is the heading difference.
    typedef enum logic [1:0] {
        MV_AHEAD = 2'd0,
        MV_RIGHT = 2'd1,
        MV_BACK  = 2'd2,
        MV_LEFT  = 2'd3
    } t_move;

    typedef struct {
        t_cmd             cmd;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_motion_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        i_cfg_data;
    logic        o_cfg_ready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    path_to_motion_commands_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state. It mirrors the converter: the held heading, the open
    // turn run and the forward blocks not yet reported, plus the diagonal mode.
    // ------------------------------------------------------------------
    logic [1:0]       hold_heading;
    logic [RUN_W-1:0] turn_run_len;
    logic             run_starts_right;
    logic             run_ends_right;
    logic [CNT_W-1:0] fwd_blocks;
    logic             diag_mode;

    t_motion_cmd step_cmds[$];      // commands caused by the step being predicted
    t_motion_cmd expected_cmds[$];  // commands still owed by the block, oldest first

    int fault_count;
    int cycle_count;

    // Stimulus control shared between the test tasks and the driver processes.
    int         src_idle_pct;
    int         snk_idle_pct;
    int         snk_hold_len;
    logic [1:0] path_heading;

    function automatic void emit(t_cmd c, logic [CNT_W-1:0] n);
        t_motion_cmd m;
        m.cmd   = c;
        m.count = n;
        m.last  = 1'b0;
        if (step_cmds.size() < MAX_RES) begin
            step_cmds.insert(step_cmds.size(), m);
        end
    endfunction

    function automatic void flush_forward();
        if (fwd_blocks != '0) begin
            emit(CMD_FWD, fwd_blocks);
            fwd_blocks = '0;
        end
    endfunction

    // A single turn stays a 90-degree turn; a longer alternating run becomes a
    // 45-degree entry, an optional diagonal and a 45-degree exit.
    function automatic void close_turn_run();
        logic [RUN_W-1:0] diag_units;
        if (turn_run_len == RUN_W'(1)) begin
            emit(run_starts_right ? CMD_R90 : CMD_L90, '0);
        end else if (turn_run_len >= RUN_W'(2)) begin
            diag_units = turn_run_len - RUN_W'(2);
            if (diag_units > RUN_W'(COUNT_MAX)) begin
                diag_units = RUN_W'(COUNT_MAX);
            end
            emit(run_starts_right ? CMD_R45 : CMD_L45, '0);
            if (diag_units != '0) begin
                emit(CMD_DIAG, diag_units[CNT_W-1:0]);
            end
            emit(run_ends_right ? CMD_R45 : CMD_L45, '0);
        end
        turn_run_len     = '0;
        run_starts_right = 1'b0;
        run_ends_right   = 1'b0;
    endfunction

    // Works out the commands caused by one accepted path step and queues them.
    function automatic void predict_step(logic [1:0] hd, logic eop);
        logic [1:0] diff;
        logic       right;
        step_cmds.delete();
        diff = hd - hold_heading;
        if (diff == 2'd2) begin
            // A reversal is reported and otherwise ignored.
            emit(CMD_ERR, '0);
        end else if (diff == 2'd0) begin
            close_turn_run();
            if (fwd_blocks < CNT_W'(COUNT_MAX)) begin
                fwd_blocks = fwd_blocks + 1'b1;
            end
            hold_heading = hd;
        end else begin
            right = (diff == 2'd1);
            flush_forward();
            if (diag_mode) begin
                if (turn_run_len != '0 && right != run_ends_right) begin
                    if (turn_run_len < RUN_W'(COUNT_MAX + 2)) begin
                        turn_run_len = turn_run_len + 1'b1;
                    end
                    run_ends_right = right;
                end else begin
                    close_turn_run();
                    turn_run_len     = RUN_W'(1);
                    run_starts_right = right;
                    run_ends_right   = right;
                end
            end else begin
                close_turn_run();
                emit(right ? CMD_R90 : CMD_L90, '0);
            end
            hold_heading = hd;
        end
        if (eop) begin
            close_turn_run();
            flush_forward();
            hold_heading = '0;
        end
        foreach (step_cmds[i]) begin
            step_cmds[i].last = (i == step_cmds.size() - 1);
            expected_cmds.insert(expected_cmds.size(), step_cmds[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard. Results are checked before the step accepted at the same
    // edge is predicted; a result always belongs to an earlier step.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_motion_cmd want;
        if (!i_rst_n) begin
            hold_heading     = '0;
            turn_run_len     = '0;
            run_starts_right = 1'b0;
            run_ends_right   = 1'b0;
            fwd_blocks       = '0;
            diag_mode        = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_cmds.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result: cmd %0d count %0d last %0b",
                                 m_axis_tdata[2:0], m_axis_tdata[12:3], m_axis_tlast);
                    end
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_axis_tdata[2:0] !== want.cmd || m_axis_tdata[12:3] !== want.count
                            || m_axis_tlast !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display({"mismatch: expected cmd %0d count %0d last %0b,",
                                      " got cmd %0d count %0d last %0b"},
                                     want.cmd, want.count, want.last,
                                     m_axis_tdata[2:0], m_axis_tdata[12:3], m_axis_tlast);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                diag_mode = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_step(s_axis_tdata[1:0], s_axis_tlast);
            end
        end
    end

    // Idle stretches are mostly short, now and then much longer.
    function automatic int pick_gap_len();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Result receiver. A requested hold-off is counted here, in cycles, while the
    // sender carries on; otherwise the ready line stalls at random.
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (snk_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (snk_hold_len - 1) @(negedge i_clk);
                snk_hold_len = 0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(99) < snk_idle_pct) begin
                    stall_left = pick_gap_len();
                end
            end
        end
    end

    // Offers one step and returns at the edge where it is taken. The valid line is
    // left high so that back-to-back steps need no second assignment in one step.
    task automatic send_step(logic [1:0] hd, logic eop);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? pick_gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, hd};
        s_axis_tlast  <= eop;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic step_move(t_move mv, logic eop);
        logic [1:0] hd;
        hd = path_heading + 2'(mv);
        if (mv != MV_BACK) begin
            path_heading = hd;
        end
        if (eop) begin
            path_heading = '0;
        end
        send_step(hd, eop);
    endtask

    // Stops offering steps and waits until every owed result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_cmds.size() != 0) @(posedge i_clk);
    endtask

    // The mode is only changed with the block idle, after its last step has settled.
    task automatic write_diag(logic value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Plain mode: merged forwards, turns in both directions through every heading,
    // reversals on their own and on the final step, and one-step paths.
    task automatic test_plain_turns();
        write_diag(1'b0);
        step_move(MV_AHEAD, 1'b0);
        step_move(MV_AHEAD, 1'b0);
        step_move(MV_AHEAD, 1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_BACK,  1'b0);
        step_move(MV_LEFT,  1'b0);
        step_move(MV_AHEAD, 1'b0);
        step_move(MV_BACK,  1'b1);
        step_move(MV_AHEAD, 1'b1);
        step_move(MV_LEFT,  1'b1);
        wait_drained();
    endtask

    // Diagonal mode: long and short alternating runs, a lone turn, a run broken by
    // a repeated direction, a reversal inside a run and a run closed by the path end.
    task automatic test_diagonal_runs();
        write_diag(1'b1);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_LEFT,  1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_LEFT,  1'b0);
        step_move(MV_AHEAD, 1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_LEFT,  1'b0);
        step_move(MV_AHEAD, 1'b0);
        step_move(MV_LEFT,  1'b0);
        step_move(MV_LEFT,  1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_BACK,  1'b0);
        step_move(MV_LEFT,  1'b1);
        step_move(MV_RIGHT, 1'b1);
        wait_drained();
    endtask

    // A run opened in diagonal mode and closed by a turn after the mode is cleared.
    task automatic test_mode_switch();
        write_diag(1'b1);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_LEFT,  1'b0);
        write_diag(1'b0);
        step_move(MV_RIGHT, 1'b0);
        step_move(MV_AHEAD, 1'b1);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while steps keep coming, so the
    // output buffer fills and the input stalls.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_diag(1'b0);
        snk_hold_len = 120;
        for (int i = 0; i < 60; i++) begin
            step_move(t_move'($urandom_range(3)), $urandom_range(7) == 0);
        end
        wait_drained();
    endtask

    // Random paths in phases of both modes, mostly well-formed: forward stretches and
    // alternating turn runs, with same-direction turns and reversals mixed in.
    task automatic test_random_paths();
        int    sent;
        int    path_len;
        int    pick;
        t_move mv;
        t_move last_turn;
        last_turn = MV_RIGHT;
        for (int phase = 0; phase < 8; phase++) begin
            write_diag((phase < 2) ? phase[0] : logic'($urandom_range(1)));
            src_idle_pct = (phase % 3 == 0) ? 0 : 30;
            snk_idle_pct = (phase % 3 == 1) ? 0 : 30;
            sent = 0;
            while (sent < 40) begin
                path_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
                for (int k = 0; k < path_len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 30) begin
                        mv = MV_AHEAD;
                    end else if (pick < 60) begin
                        mv = (last_turn == MV_RIGHT) ? MV_LEFT : MV_RIGHT;
                    end else if (pick < 77) begin
                        mv = MV_RIGHT;
                    end else if (pick < 94) begin
                        mv = MV_LEFT;
                    end else begin
                        mv = MV_BACK;
                    end
                    if (mv == MV_RIGHT || mv == MV_LEFT) begin
                        last_turn = mv;
                    end
                    step_move(mv, k == path_len - 1);
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    // Gives up if the run has not finished within a generous number of cycles.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Test sequence. Reset is held at the start and never again.
    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        fault_count   = 0;
        src_idle_pct  = 30;
        snk_idle_pct  = 30;
        snk_hold_len  = 0;
        path_heading  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_turns();
        test_diagonal_runs();
        test_mode_switch();
        test_backpressure();
        test_random_paths();

        // Let any stray result show up before the verdict.
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && expected_cmds.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
